// File: src/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB package
// Payload types, pipeline control bundle and arithmetic constants shared by
// the converter top level and its per-channel ramp unit.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	localparam int unsigned HueW     = 10;
	localparam int unsigned AngleW   = 9;
	localparam int unsigned PctW     = 7;
	localparam int unsigned LevelW   = 8;
	// intermediates on a scale of 10000
	localparam int unsigned MixW     = 14;
	// ramp on a scale of 600000
	localparam int unsigned RampW    = 20;
	// ramp * 17, so that ramp * 255 / 600000 == (ramp * 17) / 40000
	localparam int unsigned ScaledW  = 24;
	localparam int unsigned RecipW   = 17;
	localparam int unsigned ProdW    = ScaledW + RecipW;
	localparam int unsigned RecipSh  = 32;

	localparam logic [PctW-1:0]     PercentMax = 7'd100;
	localparam logic [PctW-1:0]     LigHalf    = 7'd50;
	localparam logic [HueW-1:0]     Turn       = 10'd360;
	localparam logic [HueW-1:0]     TwoTurns   = 10'd720;
	localparam logic [AngleW-1:0]   Deg60      = 9'd60;
	localparam logic [AngleW-1:0]   Deg120     = 9'd120;
	localparam logic [AngleW-1:0]   Deg180     = 9'd180;
	localparam logic [AngleW-1:0]   Deg240     = 9'd240;
	localparam logic [MixW-1:0]     MixFull    = 14'd10000;
	// floor(2^32 / 40000): estimate is exact or one low over the scaled range
	localparam logic [RecipW-1:0]   RecipMul   = 17'd107374;
	localparam logic [ScaledW-1:0]  Divisor    = 24'd40000;

	typedef struct packed {
		logic [HueW-1:0] hue_degrees;
		logic [PctW-1:0] saturation_percent;
		logic [PctW-1:0] lightness_percent;
	} hsl_in_t;

	typedef struct packed {
		logic [LevelW-1:0] red_level;
		logic [LevelW-1:0] green_level;
		logic [LevelW-1:0] blue_level;
	} rgb_out_t;

	// load enables for the stages held inside each channel unit
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

// File: src/hsl2rgb_chan.sv
// ----------------------------------------------------------------------------
// HSL to RGB channel unit
// Evaluates the four-piece hue ramp for one channel and scales it to an
// 8-bit level: ramp (stage 3), reciprocal estimate (stage 4), correction
// (stage 5).
// ----------------------------------------------------------------------------
module hsl2rgb_chan (
	input  logic                              clk,
	input  hsl2rgb_pkg::stage_en_t            en,
	input  logic [hsl2rgb_pkg::AngleW-1:0]    angle,
	input  logic [hsl2rgb_pkg::MixW-1:0]      low,
	input  logic [hsl2rgb_pkg::MixW-1:0]      high,
	output logic [hsl2rgb_pkg::LevelW-1:0]    level
);

	logic [hsl2rgb_pkg::RampW-1:0]   ramp_s3;
	logic [hsl2rgb_pkg::ScaledW-1:0] scaled_s4;
	logic [hsl2rgb_pkg::LevelW-1:0]  est_s4;
	logic [hsl2rgb_pkg::LevelW-1:0]  level_s5;

	logic [hsl2rgb_pkg::RampW:0]     ramp_sum;
	logic [hsl2rgb_pkg::ScaledW-1:0] scaled;
	logic [hsl2rgb_pkg::ProdW-1:0]   prod;
	logic [hsl2rgb_pkg::ScaledW-1:0] back;
	logic [hsl2rgb_pkg::ScaledW-1:0] rem;
	logic [hsl2rgb_pkg::LevelW-1:0]  level_d;

	always_comb begin
		logic [hsl2rgb_pkg::MixW-1:0]   span;
		logic [5:0]                     slope;
		logic [hsl2rgb_pkg::AngleW-1:0] fall;
		span  = high - low;
		fall  = hsl2rgb_pkg::Deg240 - angle;
		slope = 6'd0;
		if (angle < hsl2rgb_pkg::Deg60) begin
			slope = angle[5:0];
		end else if (angle >= hsl2rgb_pkg::Deg180 && angle < hsl2rgb_pkg::Deg240) begin
			slope = fall[5:0];
		end
		// flat top between 60 and 180 degrees
		if (angle >= hsl2rgb_pkg::Deg60 && angle < hsl2rgb_pkg::Deg180) begin
			ramp_sum = 21'(high * 6'd60);
		end else begin
			ramp_sum = 21'(low * 6'd60) + 21'(span * slope);
		end
	end

	// ramp * 255 / 600000 == ramp * 17 / 40000
	assign scaled = 24'({ramp_s3, 4'b0000}) + 24'(ramp_s3);
	assign prod   = scaled * hsl2rgb_pkg::RecipMul;

	assign back    = 24'(est_s4 * hsl2rgb_pkg::Divisor);
	assign rem     = scaled_s4 - back;
	// estimate is at most one short
	assign level_d = (rem >= hsl2rgb_pkg::Divisor) ? est_s4 + 8'd1 : est_s4;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ramp_s3 <= ramp_sum[hsl2rgb_pkg::RampW-1:0];
		end
		if (en.s4) begin
			scaled_s4 <= scaled;
			est_s4    <= prod[hsl2rgb_pkg::RecipSh +: hsl2rgb_pkg::LevelW];
		end
		if (en.s5) begin
			level_s5 <= level_d;
		end
	end

	assign level = level_s5;

endmodule

// File: src/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Five register stages: out_valid is the stage 5 valid bit, and a request
// moves through the valid bits v1_q to v5_q in stage order.
// Throughput one request per cycle; each stage stalls only when full and
// blocked downstream, so bubbles are absorbed. Reset clears the stage valid
// bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hsl2rgb_pkg::hsl_in_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hsl2rgb_pkg::rgb_out_t out_data
);

	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic en1, en2, en3, en4, en5;
	hsl2rgb_pkg::stage_en_t chan_en;

	logic [hsl2rgb_pkg::AngleW-1:0] hue_s1;
	logic [hsl2rgb_pkg::PctW-1:0]   sat_s1;
	logic [hsl2rgb_pkg::PctW-1:0]   lig_s1;

	logic [hsl2rgb_pkg::AngleW-1:0] hue_s2;
	logic [hsl2rgb_pkg::AngleW-1:0] red_s2;
	logic [hsl2rgb_pkg::AngleW-1:0] blue_s2;
	logic [hsl2rgb_pkg::MixW-1:0]   high_s2;
	logic [hsl2rgb_pkg::MixW-1:0]   low_s2;

	logic [hsl2rgb_pkg::HueW-1:0]   hue_wrap;
	logic [hsl2rgb_pkg::PctW-1:0]   sat_clip;
	logic [hsl2rgb_pkg::PctW-1:0]   lig_clip;
	logic [hsl2rgb_pkg::AngleW-1:0] red_d;
	logic [hsl2rgb_pkg::AngleW-1:0] blue_d;
	logic [hsl2rgb_pkg::MixW-1:0]   high_d;
	logic [hsl2rgb_pkg::MixW-1:0]   low_d;

	// a stage loads when empty or when the next one loads
	assign en5 = !v5_q || out_ready;
	assign en4 = !v4_q || en5;
	assign en3 = !v3_q || en4;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign in_ready = en1;
	assign chan_en  = '{s3: en3, s4: en4, s5: en5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (en1) v1_q <= in_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (en5) v5_q <= v4_q;
		end
	end

	// stage 1: wrap hue, clamp percentages
	always_comb begin
		if (in_data.hue_degrees >= hsl2rgb_pkg::TwoTurns) begin
			hue_wrap = in_data.hue_degrees - hsl2rgb_pkg::TwoTurns;
		end else if (in_data.hue_degrees >= hsl2rgb_pkg::Turn) begin
			hue_wrap = in_data.hue_degrees - hsl2rgb_pkg::Turn;
		end else begin
			hue_wrap = in_data.hue_degrees;
		end
		sat_clip = (in_data.saturation_percent > hsl2rgb_pkg::PercentMax) ?
			hsl2rgb_pkg::PercentMax : in_data.saturation_percent;
		lig_clip = (in_data.lightness_percent > hsl2rgb_pkg::PercentMax) ?
			hsl2rgb_pkg::PercentMax : in_data.lightness_percent;
	end

	// stage 2: intermediate levels and shifted angles; zero saturation
	// falls out as a flat ramp at 100*L, so no grey bypass is needed
	always_comb begin
		logic [hsl2rgb_pkg::MixW-1:0] ls;
		logic [14:0]                  l100;
		logic [14:0]                  s100;
		logic [14:0]                  hi_sum;
		logic [14:0]                  l200;
		ls     = 14'(lig_s1 * sat_s1);
		l100   = 15'(lig_s1 * 7'd100);
		s100   = 15'(sat_s1 * 7'd100);
		l200   = 15'(lig_s1 * 8'd200);
		if (lig_s1 < hsl2rgb_pkg::LigHalf) begin
			hi_sum = l100 + 15'(ls);
		end else begin
			hi_sum = l100 + s100 - 15'(ls);
		end
		high_d = hi_sum[hsl2rgb_pkg::MixW-1:0];
		low_d  = 14'(l200 - hi_sum);
		red_d  = (hue_s1 < hsl2rgb_pkg::Deg240) ? hue_s1 + hsl2rgb_pkg::Deg120 :
			hue_s1 - hsl2rgb_pkg::Deg240;
		blue_d = (hue_s1 >= hsl2rgb_pkg::Deg120) ? hue_s1 - hsl2rgb_pkg::Deg120 :
			hue_s1 + hsl2rgb_pkg::Deg240;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			hue_s1 <= hue_wrap[hsl2rgb_pkg::AngleW-1:0];
			sat_s1 <= sat_clip;
			lig_s1 <= lig_clip;
		end
		if (en2) begin
			hue_s2  <= hue_s1;
			red_s2  <= red_d;
			blue_s2 <= blue_d;
			high_s2 <= high_d;
			low_s2  <= low_d;
		end
	end

	hsl2rgb_chan u_red (
		.clk   (clk),
		.en    (chan_en),
		.angle (red_s2),
		.low   (low_s2),
		.high  (high_s2),
		.level (out_data.red_level)
	);

	hsl2rgb_chan u_green (
		.clk   (clk),
		.en    (chan_en),
		.angle (hue_s2),
		.low   (low_s2),
		.high  (high_s2),
		.level (out_data.green_level)
	);

	hsl2rgb_chan u_blue (
		.clk   (clk),
		.en    (chan_en),
		.angle (blue_s2),
		.low   (low_s2),
		.high  (high_s2),
		.level (out_data.blue_level)
	);

	assign out_valid = v5_q;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q |-> in_ready)
		else $error("input stalled with stage 1 empty");

	a_hue_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> (hue_s1 < 9'd360 && sat_s1 <= hsl2rgb_pkg::PercentMax &&
			lig_s1 <= hsl2rgb_pkg::PercentMax))
		else $error("stage 1 hue or percent out of range");

	a_mix_order: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q |-> (low_s2 <= high_s2 && high_s2 <= hsl2rgb_pkg::MixFull))
		else $error("intermediate levels out of order");

	a_red_shift: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q |-> (red_s2 < 9'd360 && blue_s2 < 9'd360 &&
			(10'(red_s2) == 10'(hue_s2) + 10'd120 || 10'(red_s2) + 10'd240 == 10'(hue_s2))))
		else $error("channel angle offset wrong");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_q && v5_q && !out_ready) |=> v4_q)
		else $error("stage 4 dropped while blocked");

endmodule
